[rtl/ssp_pkg.sv]
// ssp_pkg: shared types and constants of the shortest path block
// no dependencies; used by the interfaces, the cells and the top level
package ssp_pkg;

  localparam int DIST_BITS = 20;
  localparam int IDX_BITS  = 4;
  localparam int CNT_CFG_BITS = 5;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 20'hFFFFF;
  localparam logic [CNT_CFG_BITS-1:0] NODE_COUNT_RESET = 5'd16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RELAX,
    ST_EMIT
  } state_t;

  // running minimum carried down the cell chain
  typedef struct packed {
    logic                 found;
    logic [DIST_BITS-1:0] plen;
    logic [IDX_BITS-1:0]  idx;
  } scan_t;

  // commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic                 init;
    logic [IDX_BITS-1:0]  src;
    logic                 settle;
    logic [IDX_BITS-1:0]  settle_idx;
    logic                 relax;
    logic [IDX_BITS-1:0]  col;
    logic [DIST_BITS-1:0] cand;
  } cmd_t;

endpackage

[rtl/ssp_if.sv]
// ssp_if: request, result and configuration channels of the block
// depends on ssp_pkg for field widths
interface ssp_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] row;
  logic [3:0] col;
  logic [15:0] weight;
  logic [3:0] source_node;
  modport source (output valid, func, row, col, weight, source_node, input ready);
  modport sink (input valid, func, row, col, weight, source_node, output ready);
  modport monitor (input valid, ready, func, row, col, weight, source_node);
endinterface

interface ssp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ssp_pkg::IDX_BITS-1:0]  node_index;
  logic [ssp_pkg::DIST_BITS-1:0] distance;
  logic                          reachable;
  logic                          last;
  modport source (output valid, node_index, distance, reachable, last, input ready);
  modport sink (input valid, node_index, distance, reachable, last, output ready);
  modport monitor (input valid, ready, node_index, distance, reachable, last);
endinterface

interface ssp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ssp_pkg::CNT_CFG_BITS-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
  modport monitor (input valid, ready, data);
endinterface

[rtl/ssp_matrix.sv]
// ssp_matrix: weight matrix memory, one write and one registered read port
// standalone, no package use
module ssp_matrix #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0]    waddr,
  input  logic [WEIGHT_BITS-1:0]                    wdata,
  input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0]    raddr,
  output logic [WEIGHT_BITS-1:0]                    rdata
);
  localparam int DEPTH = MAX_NODES * MAX_NODES;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

[rtl/ssp_cell.sv]
// ssp_cell: one node of the chain, holds distance and flags of its node
// depends on ssp_pkg for scan_t and cmd_t
module ssp_cell #(
  parameter int CELL_ID = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ssp_pkg::CNT_CFG_BITS-1:0]    n_use,
  input  ssp_pkg::cmd_t                       cmd,
  input  ssp_pkg::scan_t                      scan_in,
  output ssp_pkg::scan_t                      scan_out,
  output logic [ssp_pkg::DIST_BITS-1:0]       plen,
  output logic                                reached
);
  localparam logic [ssp_pkg::IDX_BITS-1:0] MY_IDX = ssp_pkg::IDX_BITS'(CELL_ID);

  logic settled;
  logic active;
  logic cand_here;
  logic take_relax;

  assign active    = ssp_pkg::CNT_CFG_BITS'(CELL_ID) < n_use;
  assign cand_here = active && reached && !settled;
  assign take_relax = cmd.relax && (cmd.col == MY_IDX) && active &&
                      (!reached || (cmd.cand < plen));

  always_ff @(posedge clk) begin
    if (rst) begin
      reached <= 1'b0;
      settled <= 1'b0;
    end else if (cmd.init) begin
      // an inactive cell may hold the source mark but never joins a run
      reached <= (cmd.src == MY_IDX);
      settled <= 1'b0;
    end else begin
      if (cmd.settle && (cmd.settle_idx == MY_IDX)) begin
        settled <= 1'b1;
      end
      if (take_relax) begin
        reached <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      plen <= '0;
    end else if (take_relax) begin
      plen <= cmd.cand;
    end
  end

  // earlier index wins a tie, so only a strictly smaller distance replaces
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else if (cand_here && (!scan_in.found || (plen < scan_in.plen))) begin
      scan_out.found <= 1'b1;
      scan_out.plen  <= plen;
      scan_out.idx   <= MY_IDX;
    end else begin
      scan_out <= scan_in;
    end
  end
endmodule

[rtl/single_source_shortest_paths.sv]
// single_source_shortest_paths: top level, sequencer, cell chain and matrix memory
// depends on ssp_pkg, ssp_if, ssp_cell and ssp_matrix
//
//  channel | dir | fields
//  req     | in  | func, row, col, weight, source_node
//  rsp     | out | node_index, distance, reachable, last
//  cfg     | in  | data (node_count)
//
// a run does per round a chain scan and a row relax (one matrix read a cycle),
// for up to n rounds, then one last scan that finds no node, then n results
// after reset a clearing pass writes every matrix entry
// results stall the sequencer only while the output register is full
module single_source_shortest_paths #(
  parameter int MAX_NODES   = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ssp_req_if.sink    req,
  ssp_rsp_if.source  rsp,
  ssp_cfg_if.sink    cfg
);
  localparam int NLIM      = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int CIDX_BITS = $clog2(NLIM);
  localparam int CNT_BITS  = ssp_pkg::CNT_CFG_BITS;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int ADDR_BITS = $clog2(DEPTH);
  localparam int CLR_BITS  = $clog2(DEPTH + 1);
  localparam int SUM_BITS  = ((WEIGHT_BITS > ssp_pkg::DIST_BITS) ? WEIGHT_BITS
                              : ssp_pkg::DIST_BITS) + 1;

  ssp_pkg::state_t state, state_next;

  logic [CNT_BITS-1:0]  node_count;
  logic [CNT_BITS-1:0]  n_use;
  logic [CNT_BITS-1:0]  n_sel;
  logic [CLR_BITS-1:0]  clr_cnt;
  logic [CNT_BITS-1:0]  cnt;
  logic                 rd_v;
  logic [ssp_pkg::IDX_BITS-1:0]  rd_col;
  logic [ssp_pkg::IDX_BITS-1:0]  pick_idx;
  logic [ssp_pkg::DIST_BITS-1:0] pick_dist;

  logic                    req_fire;
  logic                    load_ok;
  logic                    mem_we;
  logic [ADDR_BITS-1:0]    mem_waddr;
  logic [WEIGHT_BITS-1:0]  mem_wdata;
  logic [ADDR_BITS-1:0]    mem_raddr;
  logic [WEIGHT_BITS-1:0]  mem_rdata;
  logic                    rd_issue;
  logic [SUM_BITS-1:0]     sum;
  logic [ssp_pkg::DIST_BITS-1:0] cand;
  logic                    scan_done;
  logic                    relax_done;
  logic                    emit_load;
  logic                    emit_last;

  ssp_pkg::cmd_t  cmd;
  ssp_pkg::scan_t chain [NLIM+1];
  logic [ssp_pkg::DIST_BITS-1:0] tap_dist [NLIM];
  logic                          tap_reached [NLIM];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= ssp_pkg::NODE_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      node_count <= cfg.data;
    end
  end

  always_comb begin
    if (node_count == '0) begin
      n_sel = CNT_BITS'(1);
    end else if (32'(node_count) > NLIM) begin
      n_sel = CNT_BITS'(NLIM);
    end else begin
      n_sel = node_count;
    end
  end

  // matrix memory
  assign req_fire = req.valid && req.ready;
  assign load_ok  = (32'(req.row) < MAX_NODES) && (32'(req.col) < MAX_NODES);
  assign rd_issue = (state == ssp_pkg::ST_RELAX) && (cnt < n_use);
  assign mem_raddr = ADDR_BITS'(32'(pick_idx) * MAX_NODES + 32'(cnt));

  always_comb begin
    if (state == ssp_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt[ADDR_BITS-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = req_fire && (req.func == ssp_pkg::FUNC_LOAD) && load_ok;
      mem_waddr = ADDR_BITS'(32'(req.row) * MAX_NODES + 32'(req.col));
      mem_wdata = WEIGHT_BITS'(req.weight);
    end
  end

  ssp_matrix #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_matrix (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign sum  = SUM_BITS'(pick_dist) + SUM_BITS'(mem_rdata);
  assign cand = (sum > SUM_BITS'(ssp_pkg::DIST_MAX)) ? ssp_pkg::DIST_MAX
                : sum[ssp_pkg::DIST_BITS-1:0];

  // cell chain
  assign chain[0] = '0;

  for (genvar k = 0; k < NLIM; k++) begin : g_cell
    ssp_cell #(.CELL_ID(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .n_use    (n_use),
      .cmd      (cmd),
      .scan_in  (chain[k]),
      .scan_out (chain[k+1]),
      .plen     (tap_dist[k]),
      .reached  (tap_reached[k])
    );
  end

  assign scan_done  = (state == ssp_pkg::ST_SCAN) && (32'(cnt) == NLIM);
  assign relax_done = (state == ssp_pkg::ST_RELAX) && (cnt == n_use);
  assign emit_load  = (state == ssp_pkg::ST_EMIT) && (!rsp.valid || rsp.ready);
  assign emit_last  = (cnt == n_use - CNT_BITS'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ssp_pkg::ST_CLEAR: begin
        if (32'(clr_cnt) == DEPTH - 1) state_next = ssp_pkg::ST_IDLE;
      end
      ssp_pkg::ST_IDLE: begin
        if (req_fire && (req.func == ssp_pkg::FUNC_RUN)) state_next = ssp_pkg::ST_SCAN;
      end
      ssp_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = chain[NLIM].found ? ssp_pkg::ST_RELAX : ssp_pkg::ST_EMIT;
        end
      end
      ssp_pkg::ST_RELAX: begin
        if (relax_done) state_next = ssp_pkg::ST_SCAN;
      end
      ssp_pkg::ST_EMIT: begin
        if (emit_load && emit_last) state_next = ssp_pkg::ST_IDLE;
      end
      default: state_next = ssp_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready      = (state == ssp_pkg::ST_IDLE);
    cmd.init       = req_fire && (req.func == ssp_pkg::FUNC_RUN);
    cmd.src        = req.source_node;
    cmd.settle     = scan_done && chain[NLIM].found;
    cmd.settle_idx = chain[NLIM].idx;
    cmd.relax      = rd_v && (mem_rdata != '0);
    cmd.col        = rd_col;
    cmd.cand       = cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ssp_pkg::ST_CLEAR;
      clr_cnt <= '0;
      cnt     <= '0;
      rd_v    <= 1'b0;
      n_use   <= CNT_BITS'(1);
    end else begin
      state <= state_next;
      rd_v  <= rd_issue;
      if (state == ssp_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_BITS'(1);
      end
      if (cmd.init) begin
        n_use <= n_sel;
      end
      priority if (state != state_next) begin
        cnt <= '0;
      end else if (state == ssp_pkg::ST_SCAN || state == ssp_pkg::ST_RELAX) begin
        cnt <= cnt + CNT_BITS'(1);
      end else if (emit_load) begin
        cnt <= cnt + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_col <= ssp_pkg::IDX_BITS'(cnt);
    if (cmd.settle) begin
      pick_idx  <= chain[NLIM].idx;
      pick_dist <= chain[NLIM].plen;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      rsp.node_index <= ssp_pkg::IDX_BITS'(cnt);
      rsp.reachable  <= tap_reached[cnt[CIDX_BITS-1:0]];
      rsp.distance   <= tap_reached[cnt[CIDX_BITS-1:0]] ? tap_dist[cnt[CIDX_BITS-1:0]]
                        : '0;
      rsp.last       <= emit_last;
    end
  end

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.last |-> 32'(rsp.node_index) == 32'(n_use) - 1)
    else $error("last flag on a node other than the final one");

  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.reachable |-> rsp.distance == '0)
    else $error("unreachable node with nonzero distance");

  a_pick_reached: assert property (@(posedge clk) disable iff (rst)
    cmd.settle |-> tap_reached[chain[NLIM].idx[CIDX_BITS-1:0]])
    else $error("settled a node that was never reached");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ssp_pkg::ST_CLEAR |-> !req.ready && !rsp.valid)
    else $error("channel active during matrix clear");

  a_relax_follows_settle: assert property (@(posedge clk) disable iff (rst)
    cmd.settle |=> state == ssp_pkg::ST_RELAX && cnt == '0)
    else $error("settle not followed by a row relax");
endmodule

[dv/ssp_checker.sv]
// ssp_checker: watches the request, result and configuration channels,
// predicts shortest path results and compares; depends on ssp_pkg and ssp_if
`timescale 1ns / 100ps
module ssp_checker (
  input  logic        clk,
  input  logic        rst,
  ssp_req_if.monitor  req_mon,
  ssp_rsp_if.monitor  rsp_mon,
  ssp_cfg_if.monitor  cfg_mon,
  output int          fail_count,
  output int          pending_count
);
  typedef struct packed {
    logic [ssp_pkg::IDX_BITS-1:0]  node_index;
    logic [ssp_pkg::DIST_BITS-1:0] distance;
    logic                          reachable;
    logic                          last;
  } dist_result_t;

  logic [15:0]                      edge_weight [16][16];
  logic [ssp_pkg::CNT_CFG_BITS-1:0] node_count;
  dist_result_t                     dist_queue[$];

  assign pending_count = dist_queue.size();

  // dijkstra over the first n nodes, queues one result per node
  function automatic void predict_distances(input logic [3:0] src);
    int n, pick, rnd, i;
    logic [ssp_pkg::DIST_BITS-1:0] best [16];
    bit seen [16];
    bit done [16];
    longint cand;
    dist_result_t r;
    n = node_count;
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    for (i = 0; i < 16; i++) begin
      best[i] = '0; seen[i] = 0; done[i] = 0;
    end
    if (src < n) begin
      seen[src] = 1;
      for (rnd = 0; rnd < n; rnd++) begin
        pick = n;
        for (i = 0; i < n; i++)
          if (seen[i] && !done[i] && (pick == n || best[i] < best[pick])) pick = i;
        if (pick == n) break;
        done[pick] = 1;
        for (i = 0; i < n; i++) begin
          if (edge_weight[pick][i] == 0) continue;
          cand = longint'(best[pick]) + longint'(edge_weight[pick][i]);
          if (cand > longint'(ssp_pkg::DIST_MAX)) cand = longint'(ssp_pkg::DIST_MAX);
          if (!seen[i] || cand < longint'(best[i])) begin
            seen[i] = 1;
            best[i] = cand[ssp_pkg::DIST_BITS-1:0];
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      r.node_index = i[3:0];
      r.distance   = seen[i] ? best[i] : '0;
      r.reachable  = seen[i];
      r.last       = (i == n - 1);
      dist_queue.insert(dist_queue.size(), r);
    end
  endfunction

  always @(posedge clk) begin
    dist_result_t exp_r;
    if (rst) begin
      node_count <= ssp_pkg::NODE_COUNT_RESET;
      fail_count <= 0;
      dist_queue.delete();
      for (int i = 0; i < 16; i++)
        for (int j = 0; j < 16; j++) edge_weight[i][j] = '0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) node_count <= cfg_mon.data;
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.func == ssp_pkg::FUNC_LOAD)
          edge_weight[req_mon.row][req_mon.col] = req_mon.weight;
        else
          predict_distances(req_mon.source_node);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (dist_queue.size() == 0) begin
          $error("unexpected result node_index %0d", rsp_mon.node_index);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = dist_queue.pop_front();
          if (rsp_mon.node_index !== exp_r.node_index ||
              rsp_mon.distance !== exp_r.distance ||
              rsp_mon.reachable !== exp_r.reachable || rsp_mon.last !== exp_r.last)
            fail_count <= fail_count + 1;
          if (rsp_mon.node_index !== exp_r.node_index)
            $error("node_index expected %0d actual %0d", exp_r.node_index,
                   rsp_mon.node_index);
          if (rsp_mon.distance !== exp_r.distance)
            $error("distance expected %0d actual %0d", exp_r.distance, rsp_mon.distance);
          if (rsp_mon.reachable !== exp_r.reachable)
            $error("reachable expected %0d actual %0d", exp_r.reachable,
                   rsp_mon.reachable);
          if (rsp_mon.last !== exp_r.last)
            $error("last expected %0d actual %0d", exp_r.last, rsp_mon.last);
        end
      end
    end
  end
endmodule

[dv/tb_top.sv]
// tb_top: stimulus and verdict for single_source_shortest_paths
// depends on ssp_pkg, ssp_if, the block and ssp_checker
`timescale 1ns / 100ps
module tb_top;
  logic clk;
  logic rst;
  int   fail_count, pending_count;
  int   send_idle_pct, recv_idle_pct;

  ssp_req_if req ();
  ssp_rsp_if rsp ();
  ssp_cfg_if cfg ();

  single_source_shortest_paths i_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  ssp_checker i_checker (
    .clk(clk), .rst(rst), .req_mon(req.monitor), .rsp_mon(rsp.monitor),
    .cfg_mon(cfg.monitor), .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one request; random gap before it, valid stays high into a back to back request
  task automatic send_request(input logic f, input logic [3:0] r, input logic [3:0] c,
                              input logic [15:0] w, input logic [3:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f; req.row <= r; req.col <= c; req.weight <= w; req.source_node <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // drop valid after the last request and let the checker see it
  task automatic stop_requests();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_edge(input int r, input int c, input int w);
    send_request(ssp_pkg::FUNC_LOAD, r[3:0], c[3:0], w[15:0], 4'($urandom()));
  endtask

  task automatic run_from(input int s);
    send_request(ssp_pkg::FUNC_RUN, 4'($urandom()), 4'($urandom()), 16'($urandom()),
                 s[3:0]);
  endtask

  // idle block, then write node_count
  task automatic set_node_count(input logic [4:0] value);
    stop_requests();
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic random_phase(input int items, input int maxn);
    int k;
    for (k = 0; k < items; k++) begin
      if ($urandom_range(9) < 2)
        run_from($urandom_range(maxn));
      else if ($urandom_range(9) == 0)
        load_edge($urandom_range(15), $urandom_range(15), 0);
      else if ($urandom_range(3) == 0)
        load_edge($urandom_range(15), $urandom_range(15), $urandom());
      else
        load_edge($urandom_range(maxn - 1), $urandom_range(maxn - 1),
                  $urandom_range(1, 40));
    end
  endtask

  initial begin
    rst = 1'b1;
    send_idle_pct = 6; recv_idle_pct = 69;
    req.valid = 1'b0; req.func = ssp_pkg::FUNC_LOAD; req.row = '0; req.col = '0;
    req.weight = '0; req.source_node = '0;
    cfg.valid = 1'b0; cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: empty graph, chain, extremes, self loop, out of range source
    run_from(0);
    load_edge(0, 1, 16'hFFFF);
    load_edge(1, 2, 1);
    load_edge(0, 2, 16'hFFFF);
    load_edge(2, 2, 5);
    load_edge(15, 15, 16'hFFFF);
    load_edge(2, 15, 3);
    load_edge(15, 0, 7);
    run_from(0);
    run_from(15);
    load_edge(0, 1, 0);
    run_from(0);
    set_node_count(5'd1);
    run_from(0);
    run_from(3);
    set_node_count(5'd0);
    run_from(0);
    set_node_count(5'd31);
    run_from(2);
    set_node_count(5'd4);
    run_from(5);
    run_from(1);
    random_phase(130, 4);
    set_node_count(5'd16);
    send_idle_pct = 69; recv_idle_pct = 6;
    random_phase(130, 15);
    set_node_count(5'd9);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(130, 9);
    stop_requests();
    while (pending_count != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[filelist.f]
rtl/ssp_pkg.sv
rtl/ssp_if.sv
rtl/ssp_matrix.sv
rtl/ssp_cell.sv
rtl/single_source_shortest_paths.sv
dv/ssp_checker.sv
dv/tb_top.sv
